>>> rtl/lcd_pkg.sv
// Shared types, constants and control encodings of the lidar ring curb detector.
`timescale 1ns / 1ps

package lcd_pkg;

  localparam int CoordBits   = 20;
  localparam int CfgIdxBits  = 4;
  localparam int CfgDataBits = 16;

  // configuration register indexes
  localparam logic [CfgIdxBits-1:0] CfgWindowHalf = 4'd0;
  localparam logic [CfgIdxBits-1:0] CfgHeightStep = 4'd1;
  localparam logic [CfgIdxBits-1:0] CfgCosOne     = 4'd2;
  localparam logic [CfgIdxBits-1:0] CfgCosTwo     = 4'd3;

  // geometry constants, millimetres
  localparam int NearSq   = 25000000;  // 5 m squared
  localparam int EndStep  = 50;
  localparam int IdxMmSq  = 100;       // 10 mm per index step, squared
  localparam int CosShift = 30;        // Q1.15 limit squared

  typedef logic signed [CoordBits-1:0] coord_t;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    coord_t point_z;
    logic   ring_end;
  } point_in_t;

  typedef struct packed {
    coord_t out_x;
    coord_t out_y;
    coord_t out_z;
    logic   is_curb;
    logic   last_of_ring;
  } point_out_t;

  typedef enum logic [4:0] {
    S_IDLE, S_C, S_W1, S_E1, S_F1, S_E2, S_F2, S_ACC,
    S_AW, S_OPS, S_PW, S_CHK, S_BS, S_BW, S_JUDGE, S_OUT
  } ctl_e;

  // target of the word returned by the window memory
  typedef enum logic [2:0] {LD_NONE, LD_C, LD_E, LD_F, LD_BEF, LD_AFT} ld_e;

  // product issued to the small multiplier, and where it is summed
  typedef enum logic [3:0] {
    PR_NONE, PR_NX, PR_NY, PR_DADB, PR_DADA, PR_DBDB,
    PR_SXX, PR_SYY, PR_AXX, PR_AYY, PR_BXX, PR_BYY
  } prod_e;

  // shift-add multiplies of the exact cosine compare
  typedef enum logic [1:0] {BM_DD, BM_CC, BM_RNA, BM_RNB} bm_e;

  typedef struct packed {
    ld_e   ld;
    logic  acc_clr;
    prod_e prod;
    logic  bm_start;
    bm_e   bm;
    logic  sel_two;
    logic  judge;
    logic  clr_curb;
    logic  out_load;
    logic  out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic need_slow;
    logic bm_busy;
    logic out_free;
  } dp_sts_t;

endpackage

>>> rtl/lcd_ram.sv
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module lcd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/lcd_ctrl.sv
// Controller: window bookkeeping, read sequencing and test scheduling.
`timescale 1ns / 1ps

module lcd_ctrl #(
  parameter int MAX_HALF = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_ring_end_i,
  output logic                               in_ready_o,
  input  logic [$clog2(MAX_HALF+1)-1:0]      k_i,
  input  logic                               k_clear_i,
  input  lcd_pkg::dp_sts_t                   sts_i,
  output lcd_pkg::dp_cmd_t                   cmd_o,
  output logic                               ram_we_o,
  output logic [$clog2(2*MAX_HALF+1)-1:0]    ram_waddr_o,
  output logic [$clog2(2*MAX_HALF+1)-1:0]    ram_raddr_o
);

  import lcd_pkg::*;

  localparam int D   = 2 * MAX_HALF + 1;
  localparam int AW  = $clog2(D);
  localparam int NW  = AW + 1;
  localparam int KW  = $clog2(MAX_HALF + 1);
  localparam int Cap = 4 * MAX_HALF + 1;
  localparam int CW  = $clog2(Cap + 1);
  localparam int EW  = CW + 2;

  ctl_e           state_q, state_d;
  logic [CW-1:0]  rc_q, rc_d, rcn;
  logic [AW-1:0]  ws_q, ws_d;
  logic [KW-1:0]  b_q, b_d, m_q, m_d, h1, h2;
  logic           ph_q, ph_d, end_q, end_d, two_q, two_d;
  logic [2:0]     op_q, op_d;
  bm_e            bm_q, bm_d;
  ld_e            ld_q, ld_d;
  logic [NW-1:0]  n, sum_a;
  logic           t1v, t2v, op_last;

  // product order of each test
  function automatic prod_e op_prod(input logic two, input logic [2:0] op);
    prod_e p;
    p = PR_NONE;
    case (op)
      3'd0:    p = PR_NX;
      3'd1:    p = PR_NY;
      3'd2:    p = two ? PR_SXX : PR_DADB;
      3'd3:    p = two ? PR_SYY : PR_DADA;
      3'd4:    p = two ? PR_AXX : PR_DBDB;
      3'd5:    p = PR_AYY;
      3'd6:    p = PR_BXX;
      3'd7:    p = PR_BYY;
      default: p = PR_NONE;
    endcase
    return p;
  endfunction

  assign h1  = k_i >> 1;
  assign h2  = k_i - h1;
  assign rcn = (rc_q == CW'(Cap)) ? rc_q : rc_q + 1'b1;

  // neighbour limits inside the ring
  assign t1v = (b_q >= h2) && (EW'(rc_q) >= EW'(b_q) + EW'(k_i) + EW'(h1) + 1'b1);
  assign t2v = (b_q >= k_i) && (EW'(rc_q) >= EW'(b_q) + EW'(k_i) + 1'b1);
  assign op_last = two_q ? (op_q == 3'd7) : (op_q == 3'd4);

  // window slot of the point n back from the newest
  assign sum_a = NW'(ws_q) + NW'(D - 1) - n;
  assign ram_raddr_o = (sum_a >= NW'(D)) ? AW'(sum_a - NW'(D)) : AW'(sum_a);
  assign ram_waddr_o = ws_q;

  // state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rc_q    <= '0;
      ws_q    <= '0;
      b_q     <= '0;
      m_q     <= '0;
      ph_q    <= 1'b0;
      end_q   <= 1'b0;
      two_q   <= 1'b0;
      op_q    <= '0;
      bm_q    <= BM_DD;
      ld_q    <= LD_NONE;
    end else begin
      state_q <= state_d;
      rc_q    <= rc_d;
      ws_q    <= ws_d;
      b_q     <= b_d;
      m_q     <= m_d;
      ph_q    <= ph_d;
      end_q   <= end_d;
      two_q   <= two_d;
      op_q    <= op_d;
      bm_q    <= bm_d;
      ld_q    <= ld_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    rc_d    = rc_q;
    ws_d    = ws_q;
    b_d     = b_q;
    m_d     = m_q;
    ph_d    = ph_q;
    end_d   = end_q;
    two_d   = two_q;
    op_d    = op_q;
    bm_d    = bm_q;
    ld_d    = LD_NONE;
    n       = NW'(b_q);
    in_ready_o = 1'b0;
    ram_we_o   = 1'b0;
    cmd_o         = '0;
    cmd_o.ld      = ld_q;
    cmd_o.sel_two = two_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ram_we_o = 1'b1;
          ws_d  = (ws_q == AW'(D - 1)) ? '0 : ws_q + 1'b1;
          rc_d  = rcn;
          end_d = in_ring_end_i;
          if (in_ring_end_i) begin
            b_d     = (EW'(rcn) - 1'b1 < EW'(k_i)) ? KW'(rcn - 1'b1) : k_i;
            state_d = S_C;
          end else if (EW'(rcn) >= EW'(k_i) + 1'b1) begin
            b_d     = k_i;
            state_d = S_C;
          end
        end
      end
      S_C: begin
        ld_d = LD_C;
        cmd_o.clr_curb = 1'b1;
        two_d = 1'b0;
        if (t1v) begin
          state_d = S_E1;
        end else if (t2v) begin
          two_d   = 1'b1;
          state_d = S_E2;
        end else begin
          state_d = S_W1;
        end
      end
      S_W1: state_d = S_OUT;
      S_E1: begin
        n = NW'(b_q) + NW'(h1);
        ld_d = LD_E;
        state_d = S_F1;
      end
      S_F1: begin
        n = NW'(b_q) - NW'(h2);
        ld_d = LD_F;
        op_d = '0;
        state_d = S_AW;
      end
      S_E2: begin
        n = NW'(b_q) + NW'(k_i);
        ld_d = LD_E;
        state_d = S_F2;
      end
      S_F2: begin
        n = NW'(b_q) - NW'(k_i);
        ld_d = LD_F;
        cmd_o.acc_clr = 1'b1;
        m_d  = KW'(1);
        ph_d = 1'b0;
        state_d = S_ACC;
      end
      S_ACC: begin
        if (!ph_q) begin
          n = NW'(b_q) + NW'(m_q);
          ld_d = LD_BEF;
          ph_d = 1'b1;
        end else begin
          n = NW'(b_q) - NW'(m_q);
          ld_d = LD_AFT;
          ph_d = 1'b0;
          m_d  = m_q + 1'b1;
          if (m_q == k_i) begin
            op_d    = '0;
            state_d = S_AW;
          end
        end
      end
      S_AW: state_d = S_OPS;
      S_OPS: begin
        cmd_o.prod = op_prod(two_q, op_q);
        op_d = op_q + 1'b1;
        if (op_last) begin
          state_d = S_PW;
        end
      end
      S_PW: state_d = S_CHK;
      S_CHK: begin
        if (sts_i.need_slow) begin
          bm_d    = BM_DD;
          state_d = S_BS;
        end else begin
          state_d = S_JUDGE;
        end
      end
      S_BS: begin
        cmd_o.bm_start = 1'b1;
        cmd_o.bm       = bm_q;
        state_d = S_BW;
      end
      S_BW: begin
        if (!sts_i.bm_busy) begin
          unique case (bm_q)
            BM_DD:   begin bm_d = BM_CC;  state_d = S_BS; end
            BM_CC:   begin bm_d = BM_RNA; state_d = S_BS; end
            BM_RNA:  begin bm_d = BM_RNB; state_d = S_BS; end
            default: state_d = S_JUDGE;
          endcase
        end
      end
      S_JUDGE: begin
        cmd_o.judge = 1'b1;
        if (!two_q && t2v) begin
          two_d   = 1'b1;
          state_d = S_E2;
        end else begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = end_q && (b_q == '0);
          if (end_q && (b_q != '0)) begin
            b_d     = b_q - 1'b1;
            state_d = S_C;
          end else begin
            if (end_q) begin
              rc_d = '0;
            end
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
    // a new K starts a fresh ring
    if (k_clear_i) begin
      rc_d = '0;
    end
  end

endmodule

>>> rtl/lcd_dp.sv
// Datapath: point registers, sums and maxima, multipliers, cosine compare, output word.
`timescale 1ns / 1ps

module lcd_dp #(
  parameter int MAX_HALF = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lcd_pkg::dp_cmd_t                    cmd_i,
  output lcd_pkg::dp_sts_t                    sts_o,
  input  logic [$clog2(MAX_HALF+1)-1:0]       k_i,
  input  logic [9:0]                          height_step_i,
  input  logic signed [15:0]                  cos_one_i,
  input  logic signed [15:0]                  cos_two_i,
  input  logic [3*lcd_pkg::CoordBits-1:0]     rdata_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output lcd_pkg::point_out_t                 out_data_o
);

  import lcd_pkg::*;

  localparam int CB = CoordBits;
  localparam int KW = $clog2(MAX_HALF + 1);
  localparam int SW = CB + 1 + KW;            // side sums
  localparam int PW = 2 * SW + 1;             // dot products and norms
  localparam int BW = 2 * PW + CosShift + 2;  // exact cosine compare
  localparam int HW = 2 * KW + 7;             // index spacing terms

  // memory word
  logic signed [CB-1:0] rx, ry, rz;
  logic [CB-1:0]        rz_abs, cz_abs;

  // point registers
  logic signed [CB-1:0] cx_q, cy_q, cz_q, ex_q, ey_q, ez_q, fx_q, fy_q, fz_q;
  logic signed [SW-1:0] sax_q, say_q, sbx_q, sby_q;
  logic [CB-1:0]        m1_q, m2_q;

  // products
  logic signed [SW-1:0]   op_a, op_b, da, db, ndx, ndy, de;
  logic signed [2*SW-1:0] pr;
  logic signed [PW-1:0]   prod_q, dot_q;
  prod_e                  tag_q;
  logic [PW-1:0]          near_q, na_q, nb_q;
  logic [KW-1:0]          h1, h2;
  logic [HW-1:0]          c12, c11, c22;

  // shift-add multiplier
  logic          busy_q;
  bm_e           bmt_q;
  logic [BW-1:0] ma_q, acc_q, lhs_q, rhs_q;
  logic [PW-1:0] mb_q, dmag;
  logic [15:0]   cmag;

  // decisions
  logic signed [15:0] lim;
  logic          zero_n, neg, quick, quick_val, cos_ok, near_ok, ok1, ok2;
  logic [SW-1:0] da_abs, db_abs, de_abs, hs_w;
  logic [CB-1:0] hs_c, g1, g2, gm;
  logic          curb_q, out_valid_q;
  point_out_t    out_q;

  assign rx = $signed(rdata_i[3*CB-1:2*CB]);
  assign ry = $signed(rdata_i[2*CB-1:CB]);
  assign rz = $signed(rdata_i[CB-1:0]);
  assign rz_abs = rz[CB-1] ? CB'(-rz) : CB'(rz);
  assign cz_abs = cz_q[CB-1] ? CB'(-cz_q) : CB'(cz_q);

  // point loads
  always_ff @(posedge clk_i) begin
    case (cmd_i.ld)
      LD_C: begin cx_q <= rx; cy_q <= ry; cz_q <= rz; end
      LD_E: begin ex_q <= rx; ey_q <= ry; ez_q <= rz; end
      LD_F: begin fx_q <= rx; fy_q <= ry; fz_q <= rz; end
      default: ;
    endcase
  end

  // side sums of vectors from the centre and |z| peaks
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_clr) begin
      sax_q <= '0;
      say_q <= '0;
      sbx_q <= '0;
      sby_q <= '0;
      m1_q  <= cz_abs;
      m2_q  <= cz_abs;
    end else begin
      case (cmd_i.ld)
        LD_BEF: begin
          sax_q <= sax_q + SW'(rx) - SW'(cx_q);
          say_q <= say_q + SW'(ry) - SW'(cy_q);
          if (rz_abs > m1_q) m1_q <= rz_abs;
        end
        LD_AFT: begin
          sbx_q <= sbx_q + SW'(rx) - SW'(cx_q);
          sby_q <= sby_q + SW'(ry) - SW'(cy_q);
          if (rz_abs > m2_q) m2_q <= rz_abs;
        end
        default: ;
      endcase
    end
  end

  assign da  = SW'(ez_q) - SW'(cz_q);
  assign db  = SW'(fz_q) - SW'(cz_q);
  assign de  = SW'(ez_q) - SW'(fz_q);
  assign ndx = SW'(ex_q) - SW'(fx_q);
  assign ndy = SW'(ey_q) - SW'(fy_q);

  // index spacing terms of the triangle
  assign h1  = k_i >> 1;
  assign h2  = k_i - h1;
  assign c12 = HW'(h1) * HW'(h2) * HW'(IdxMmSq);
  assign c11 = HW'(h1) * HW'(h1) * HW'(IdxMmSq);
  assign c22 = HW'(h2) * HW'(h2) * HW'(IdxMmSq);

  // small multiplier operand select
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd_i.prod)
      PR_NX:   begin op_a = ndx;   op_b = ndx;   end
      PR_NY:   begin op_a = ndy;   op_b = ndy;   end
      PR_DADB: begin op_a = da;    op_b = db;    end
      PR_DADA: begin op_a = da;    op_b = da;    end
      PR_DBDB: begin op_a = db;    op_b = db;    end
      PR_SXX:  begin op_a = sax_q; op_b = sbx_q; end
      PR_SYY:  begin op_a = say_q; op_b = sby_q; end
      PR_AXX:  begin op_a = sax_q; op_b = sax_q; end
      PR_AYY:  begin op_a = say_q; op_b = say_q; end
      PR_BXX:  begin op_a = sbx_q; op_b = sbx_q; end
      PR_BYY:  begin op_a = sby_q; op_b = sby_q; end
      default: ;
    endcase
  end

  assign pr = op_a * op_b;

  always_ff @(posedge clk_i) begin
    prod_q <= PW'(pr);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= PR_NONE;
    end else begin
      tag_q <= cmd_i.prod;
    end
  end

  // product summing, in the cycle after the multiply
  always_ff @(posedge clk_i) begin
    case (tag_q)
      PR_NX:   near_q <= $unsigned(prod_q);
      PR_NY:   near_q <= near_q + $unsigned(prod_q);
      PR_DADB: dot_q  <= prod_q - $signed(PW'(c12));
      PR_DADA: na_q   <= $unsigned(prod_q) + PW'(c11);
      PR_DBDB: nb_q   <= $unsigned(prod_q) + PW'(c22);
      PR_SXX:  dot_q  <= prod_q;
      PR_SYY:  dot_q  <= dot_q + prod_q;
      PR_AXX:  na_q   <= $unsigned(prod_q);
      PR_AYY:  na_q   <= na_q + $unsigned(prod_q);
      PR_BXX:  nb_q   <= $unsigned(prod_q);
      PR_BYY:  nb_q   <= nb_q + $unsigned(prod_q);
      default: ;
    endcase
  end

  // cosine sign shortcuts
  assign lim       = cmd_i.sel_two ? cos_two_i : cos_one_i;
  assign zero_n    = (na_q == '0) || (nb_q == '0);
  assign neg       = dot_q[PW-1];
  assign quick     = zero_n || (!neg && (lim <= 0)) || (neg && (lim >= 0));
  assign quick_val = !zero_n && !neg && (lim <= 0);
  assign dmag      = neg ? PW'(-dot_q) : PW'(dot_q);
  assign cmag      = lim[15] ? 16'(-lim) : 16'(lim);

  // shift-add multiplier, one bit of the multiplier a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      bmt_q  <= BM_DD;
    end else if (cmd_i.bm_start) begin
      busy_q <= 1'b1;
      bmt_q  <= cmd_i.bm;
    end else if (busy_q && (mb_q == '0)) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.bm_start) begin
      acc_q <= '0;
      case (cmd_i.bm)
        BM_DD:   begin ma_q <= BW'(dmag);  mb_q <= dmag;       end
        BM_CC:   begin ma_q <= BW'(cmag);  mb_q <= PW'(cmag);  end
        BM_RNA:  begin ma_q <= rhs_q;      mb_q <= na_q;       end
        default: begin ma_q <= rhs_q;      mb_q <= nb_q;       end
      endcase
    end else if (busy_q) begin
      if (mb_q == '0) begin
        if (bmt_q == BM_DD) begin
          lhs_q <= acc_q << CosShift;
        end else begin
          rhs_q <= acc_q;
        end
      end else begin
        if (mb_q[0]) acc_q <= acc_q + ma_q;
        ma_q <= ma_q << 1;
        mb_q <= mb_q >> 1;
      end
    end
  end

  assign cos_ok = quick ? quick_val : (neg ? (lhs_q <= rhs_q) : (lhs_q >= rhs_q));

  // height and spacing conditions
  assign near_ok = near_q < PW'(NearSq);
  assign da_abs  = da[SW-1] ? SW'(-da) : SW'(da);
  assign db_abs  = db[SW-1] ? SW'(-db) : SW'(db);
  assign de_abs  = de[SW-1] ? SW'(-de) : SW'(de);
  assign hs_w    = SW'(height_step_i);
  assign hs_c    = CB'(height_step_i);
  assign g1      = m1_q - cz_abs;
  assign g2      = m2_q - cz_abs;
  assign gm      = (m1_q >= m2_q) ? m1_q - m2_q : m2_q - m1_q;
  assign ok1     = near_ok && ((da_abs >= hs_w) || (db_abs >= hs_w)) &&
                   (de_abs >= SW'(EndStep));
  assign ok2     = near_ok && ((g1 >= hs_c) || (g2 >= hs_c)) && (gm >= CB'(EndStep));

  // curb mark
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_curb) begin
      curb_q <= 1'b0;
    end else if (cmd_i.judge) begin
      curb_q <= curb_q | ((cmd_i.sel_two ? ok2 : ok1) && cos_ok);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.out_x        <= cx_q;
      out_q.out_y        <= cy_q;
      out_q.out_z        <= cz_q;
      out_q.is_curb      <= curb_q;
      out_q.last_of_ring <= cmd_i.out_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_data_o       = out_q;
  assign sts_o.need_slow  = !quick;
  assign sts_o.bm_busy    = busy_q;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

endmodule

>>> rtl/lidar_ring_curb_detector_top.sv
// Top level of the lidar ring curb detector: configuration registers and wiring.
//
//  channel  signals                                 word
//  in       in_valid_i / in_ready_o / in_data_i     one ring point
//  out      out_valid_o / out_ready_i / out_data_o  one classified point
//  cfg      cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i  register write
//
// A point is taken while the controller is idle; one that completes a window or ends a ring then
// yields 1 to K+1 results. Each result reads its centre, runs the triangle test, the mean vector
// test, both or neither, and is loaded into the output register. Each test whose cosine sign
// does not decide it adds four shift-add multiplies.
// Reset empties the ring; the window memory needs no clearing.
// The output register lets the controller run on to the next load while a word waits.
`timescale 1ns / 1ps

module lidar_ring_curb_detector_top #(
  parameter int MAX_HALF = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  lcd_pkg::point_in_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output lcd_pkg::point_out_t                 out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lcd_pkg::CfgIdxBits-1:0]      cfg_index_i,
  input  logic [lcd_pkg::CfgDataBits-1:0]     cfg_data_i
);

  import lcd_pkg::*;

  localparam int D  = 2 * MAX_HALF + 1;
  localparam int AW = $clog2(D);
  localparam int KW = $clog2(MAX_HALF + 1);

  logic [4:0]          k_raw_q;
  logic [9:0]          hs_q;
  logic signed [15:0]  c1_q, c2_q;
  logic [KW-1:0]       k_eff;
  logic                cfg_wr, k_clear;
  dp_cmd_t             cmd;
  dp_sts_t             sts;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [3*CoordBits-1:0] ram_rdata;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign k_clear     = cfg_wr && (cfg_index_i == CfgWindowHalf);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_raw_q <= 5'd4;
      hs_q    <= 10'd100;
      c1_q    <= '0;
      c2_q    <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_index_i)
        CfgWindowHalf: k_raw_q <= cfg_data_i[4:0];
        CfgHeightStep: hs_q    <= cfg_data_i[9:0];
        CfgCosOne:     c1_q    <= $signed(cfg_data_i);
        CfgCosTwo:     c2_q    <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // K held to 2..MAX_HALF
  always_comb begin
    if (k_raw_q < 5'd2) begin
      k_eff = KW'(2);
    end else if (int'(k_raw_q) > MAX_HALF) begin
      k_eff = KW'(MAX_HALF);
    end else begin
      k_eff = KW'(k_raw_q);
    end
  end

  lcd_ram #(
    .Width (3 * CoordBits),
    .Depth (D)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({in_data_i.point_x, in_data_i.point_y, in_data_i.point_z}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  lcd_ctrl #(
    .MAX_HALF (MAX_HALF)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ring_end_i (in_data_i.ring_end),
    .in_ready_o    (in_ready_o),
    .k_i           (k_eff),
    .k_clear_i     (k_clear),
    .sts_i         (sts),
    .cmd_o         (cmd),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_raddr_o   (ram_raddr)
  );

  lcd_dp #(
    .MAX_HALF (MAX_HALF)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .k_i           (k_eff),
    .height_step_i (hs_q),
    .cos_one_i     (c1_q),
    .cos_two_i     (c2_q),
    .rdata_i       (ram_rdata),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .out_data_o    (out_data_o)
  );

endmodule
